@@ src/rnop_pkg.sv @@
// rnop_pkg: widths, constants, register indexes and shared types for the ray
// nearest-obstacle search. No dependencies.
package rnop_pkg;

    localparam int CoordW           = 12;  // map coordinate width
    localparam int EndW             = 14;  // ray end / result coordinate width
    localparam int DeltaW           = 15;  // end - origin, signed
    localparam int RelW             = 13;  // point - origin, signed
    localparam int ProdW            = 28;  // rel * delta, signed
    localparam int DotW             = 29;  // dot / cross product, signed
    localparam int SqDW             = 28;  // delta squared
    localparam int Len2W            = 29;  // squared ray length
    localparam int PerpW            = 15;
    localparam int ThrW             = 28;  // perpendicular threshold
    localparam int RelSqW           = 25;  // rel squared
    localparam int R2W              = 26;  // squared distance to origin
    localparam int CabsW            = 14;  // |cross| range that can still pass
    localparam int CsqW             = 28;
    localparam int IdxW             = 3;
    localparam int CfgDataW         = 14;
    localparam int DeriveLat        = 4;   // cycles from a write to valid derived values
    localparam int BusyW            = 3;
    localparam int CandDepth        = 4;
    localparam int HitDepth         = 2;
    localparam int CoordBitsDefault = 12;

    // 0.707^2 in Q16
    localparam logic [PerpW-1:0] PerpQ16 = 15'd32758;

    typedef enum logic [IdxW-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_END_X    = 3'd2,
        REG_END_Y    = 3'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [DeltaW-1:0] dx;
        logic signed [DeltaW-1:0] dy;
        logic [Len2W-1:0]         len2;
        logic [ThrW-1:0]          thr;
        logic                     zero_len;
        logic [CoordW-1:0]        origin_x;
        logic [CoordW-1:0]        origin_y;
        logic signed [EndW-1:0]   end_x;
        logic signed [EndW-1:0]   end_y;
    } t_ray;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              last;
    } t_tag;

    typedef struct packed {
        logic              qual;
        logic [R2W-1:0]    r2;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              last;
    } t_cand;

    typedef struct packed {
        logic signed [EndW-1:0] x;
        logic signed [EndW-1:0] y;
        logic                   found;
    } t_hit;

    typedef struct packed {
        logic idle;      // no item in the front pipeline
        logic push;      // candidate written to the queue this cycle
    } t_front_stat;

endpackage

@@ src/rnop_fifo.sv @@
// rnop_fifo: small synchronous queue, flip-flop storage.
// Depends on nothing; used for the candidate queue and the result queue.
module rnop_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

@@ src/rnop_cfg.sv @@
// rnop_cfg: ray registers and the derived ray values (delta, length, threshold).
// Depends on rnop_pkg.
module rnop_cfg #(
    parameter logic [rnop_pkg::CoordW-1:0] COORD_MASK = '1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rnop_pkg::IdxW-1:0]     i_cfg_index,
    input  logic [rnop_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_idle,
    output rnop_pkg::t_ray                o_ray,
    output logic                          o_busy,
    output logic                          o_restart
);
    import rnop_pkg::*;

    logic [CoordW-1:0]        r_origin_x, r_origin_y;
    logic signed [EndW-1:0]   r_end_x, r_end_y;
    logic signed [DeltaW-1:0] r_dx, r_dy;
    logic [SqDW-1:0]          r_dx2, r_dy2;
    logic [Len2W-1:0]         r_len2;
    logic [ThrW-1:0]          r_thr;
    logic [BusyW-1:0]         r_busy, n_busy;
    logic                     wr;
    logic signed [2*DeltaW-1:0] sq_x, sq_y;
    logic [Len2W+PerpW-1:0]   thr_prod;

    assign o_cfg_ready = i_idle;
    assign wr          = i_cfg_valid && o_cfg_ready;
    assign o_restart   = wr && (i_cfg_index == REG_ORIGIN_X || i_cfg_index == REG_ORIGIN_Y ||
                                i_cfg_index == REG_END_X || i_cfg_index == REG_END_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_end_x    <= '0;
            r_end_y    <= '0;
        end else if (wr) begin
            case (i_cfg_index)
                REG_ORIGIN_X: r_origin_x <= i_cfg_data[CoordW-1:0] & COORD_MASK;
                REG_ORIGIN_Y: r_origin_y <= i_cfg_data[CoordW-1:0] & COORD_MASK;
                REG_END_X:    r_end_x    <= $signed(i_cfg_data);
                REG_END_Y:    r_end_y    <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // derived values follow the registers with a fixed latency
    assign sq_x     = r_dx * r_dx;
    assign sq_y     = r_dy * r_dy;
    assign thr_prod = r_len2 * PerpQ16;

    always_ff @(posedge i_clk) begin
        r_dx   <= $signed({r_end_x[EndW-1], r_end_x})
                - $signed({{(DeltaW-CoordW){1'b0}}, r_origin_x});
        r_dy   <= $signed({r_end_y[EndW-1], r_end_y})
                - $signed({{(DeltaW-CoordW){1'b0}}, r_origin_y});
        r_dx2  <= sq_x[SqDW-1:0];
        r_dy2  <= sq_y[SqDW-1:0];
        r_len2 <= {1'b0, r_dx2} + {1'b0, r_dy2};
        r_thr  <= thr_prod[Len2W+PerpW-1:16];
    end

    always_comb begin
        n_busy = r_busy;
        if (o_restart) begin
            n_busy = BusyW'(DeriveLat);
        end else if (r_busy != '0) begin
            n_busy = r_busy - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= BusyW'(DeriveLat);
        end else begin
            r_busy <= n_busy;
        end
    end

    assign o_busy         = (r_busy != '0);
    assign o_ray.dx       = r_dx;
    assign o_ray.dy       = r_dy;
    assign o_ray.len2     = r_len2;
    assign o_ray.thr      = r_thr;
    assign o_ray.zero_len = (r_len2 == '0);
    assign o_ray.origin_x = r_origin_x;
    assign o_ray.origin_y = r_origin_y;
    assign o_ray.end_x    = r_end_x;
    assign o_ray.end_y    = r_end_y;
endmodule

@@ src/rnop_front.sv @@
// rnop_front: accepts obstacle points and classifies them against the ray in a
// five-stage pipeline. Depends on rnop_pkg; feeds the candidate queue.
module rnop_front #(
    parameter logic [rnop_pkg::CoordW-1:0] COORD_MASK = '1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [rnop_pkg::CoordW-1:0] i_obs_x,
    input  logic [rnop_pkg::CoordW-1:0] i_obs_y,
    input  logic                        i_last,
    output logic                        o_full,
    input  rnop_pkg::t_ray              i_ray,
    input  logic                        i_derive_busy,
    output rnop_pkg::t_cand             o_cand,
    input  logic                        i_cand_full,
    output rnop_pkg::t_front_stat       o_stat
);
    import rnop_pkg::*;

    logic adv, acc;
    logic [CoordW-1:0] px, py;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_tag r_t1, r_t2, r_t3, r_t4, r_t5;

    logic signed [RelW-1:0]  r_rx, r_ry;
    logic signed [ProdW-1:0] r_xdx, r_ydy, r_xdy, r_ydx;
    logic [RelSqW-1:0]       r_xx, r_yy;
    logic signed [DotW-1:0]  r_dot, r_crs;
    logic [R2W-1:0]          r_r2_3, r_r2_4, r_r2_5;
    logic                    r_on4, r_on5;
    logic [CabsW-1:0]        r_cabs;
    logic [CsqW-1:0]         r_csq;

    logic signed [ProdW-1:0] p_xx, p_yy;
    logic [DotW-1:0]         crs_abs;

    assign adv    = !(r_v5 && i_cand_full);
    assign o_full = i_derive_busy || !adv;
    assign acc    = i_push && !o_full;
    assign px     = i_obs_x & COORD_MASK;
    assign py     = i_obs_y & COORD_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign p_xx    = r_rx * r_rx;
    assign p_yy    = r_ry * r_ry;
    assign crs_abs = r_crs[DotW-1] ? unsigned'(-r_crs) : unsigned'(r_crs);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // relative position
            r_rx <= $signed({1'b0, px}) - $signed({1'b0, i_ray.origin_x});
            r_ry <= $signed({1'b0, py}) - $signed({1'b0, i_ray.origin_y});
            r_t1 <= '{x: px, y: py, last: i_last};
            // products
            r_xdx <= r_rx * i_ray.dx;
            r_ydy <= r_ry * i_ray.dy;
            r_xdy <= r_rx * i_ray.dy;
            r_ydx <= r_ry * i_ray.dx;
            r_xx  <= p_xx[RelSqW-1:0];
            r_yy  <= p_yy[RelSqW-1:0];
            r_t2  <= r_t1;
            // dot, cross, squared distance
            r_dot  <= $signed({r_xdx[ProdW-1], r_xdx}) + $signed({r_ydy[ProdW-1], r_ydy});
            r_crs  <= $signed({r_xdy[ProdW-1], r_xdy}) - $signed({r_ydx[ProdW-1], r_ydx});
            r_r2_3 <= {1'b0, r_xx} + {1'b0, r_yy};
            r_t3   <= r_t2;
            // projection on segment, cross small enough to square narrow
            r_on4  <= !r_dot[DotW-1] && (unsigned'(r_dot) <= i_ray.len2)
                      && (crs_abs[DotW-1:CabsW] == '0);
            r_cabs <= crs_abs[CabsW-1:0];
            r_r2_4 <= r_r2_3;
            r_t4   <= r_t3;
            // squared cross
            r_csq  <= r_cabs * r_cabs;
            r_on5  <= r_on4;
            r_r2_5 <= r_r2_4;
            r_t5   <= r_t4;
        end
    end

    assign o_cand.qual = r_on5 && (r_csq <= i_ray.thr) && !i_ray.zero_len;
    assign o_cand.r2   = r_r2_5;
    assign o_cand.x    = r_t5.x;
    assign o_cand.y    = r_t5.y;
    assign o_cand.last = r_t5.last;

    assign o_stat.idle = !(r_v1 || r_v2 || r_v3 || r_v4 || r_v5);
    assign o_stat.push = r_v5 && !i_cand_full;
endmodule

@@ src/rnop_back.sv @@
// rnop_back: running minimum over classified candidates, emits one result on
// the last point of a ray. Depends on rnop_pkg.
module rnop_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rnop_pkg::t_cand i_cand,
    input  logic            i_cand_empty,
    output logic            o_cand_pop,
    input  rnop_pkg::t_ray  i_ray,
    input  logic            i_restart,
    output rnop_pkg::t_hit  o_hit,
    output logic            o_hit_push,
    input  logic            i_hit_full
);
    import rnop_pkg::*;

    logic                    r_found;
    logic [R2W-1:0]          r_best_d;
    logic [CoordW-1:0]       r_best_x, r_best_y;
    logic                    upd;
    logic [Len2W-1:0]        bound;
    logic signed [EndW-1:0]  cur_x, cur_y;

    assign o_cand_pop = !i_cand_empty && (!i_cand.last || !i_hit_full);
    assign bound      = r_found ? {{(Len2W-R2W){1'b0}}, r_best_d} : i_ray.len2;
    assign upd        = i_cand.qual && ({{(Len2W-R2W){1'b0}}, i_cand.r2} < bound);
    assign o_hit_push = o_cand_pop && i_cand.last;

    always_comb begin
        if (upd) begin
            cur_x = $signed({{(EndW-CoordW){1'b0}}, i_cand.x});
            cur_y = $signed({{(EndW-CoordW){1'b0}}, i_cand.y});
        end else if (r_found) begin
            cur_x = $signed({{(EndW-CoordW){1'b0}}, r_best_x});
            cur_y = $signed({{(EndW-CoordW){1'b0}}, r_best_y});
        end else begin
            cur_x = i_ray.end_x;
            cur_y = i_ray.end_y;
        end
        if (i_ray.zero_len) begin
            o_hit.x     = $signed({{(EndW-CoordW){1'b0}}, i_ray.origin_x});
            o_hit.y     = $signed({{(EndW-CoordW){1'b0}}, i_ray.origin_y});
            o_hit.found = 1'b0;
        end else begin
            o_hit.x     = cur_x;
            o_hit.y     = cur_y;
            o_hit.found = upd || r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_restart) begin
            r_found <= 1'b0;
        end else if (o_cand_pop) begin
            if (i_cand.last) begin
                r_found <= 1'b0;
            end else if (upd) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cand_pop && upd) begin
            r_best_d <= i_cand.r2;
            r_best_x <= i_cand.x;
            r_best_y <= i_cand.y;
        end
    end
endmodule

@@ src/ray_nearest_obstacle_point.sv @@
// ray_nearest_obstacle_point: top level of the nearest-obstacle ray search.
// Depends on rnop_pkg, rnop_cfg, rnop_front, rnop_fifo and rnop_back.
//
// Casts one ray from the configured origin to the configured end point and
// keeps the nearest streamed obstacle pixel lying within about 0.707 px of the
// segment; all tests are exact integer squared compares. Points enter through
// push/full at one per cycle unless the ray is recomputed or the candidate
// queue backs up; the front pipeline (five stages of products, dot/cross sums
// and the squared-cross threshold test) writes into a four-entry candidate
// queue, and the back end folds one candidate per cycle into the running
// minimum unless a last point meets a full result queue. A ray's result goes
// to the output queue (two entries, empty/pop) when its last point leaves the
// candidate queue; each last-marked point yields one result. Register writes
// (origin x/y, end x/y at indexes 0..3) are taken only when no point is in
// flight; afterwards, and after reset, full stays high while the ray length
// and distance threshold are recomputed. Writes to other indexes are ignored.
module ray_nearest_obstacle_point #(
    parameter int COORD_BITS = rnop_pkg::CoordBitsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // obstacle request channel
    input  logic                          push,
    output logic                          full,
    input  logic [rnop_pkg::CoordW-1:0]   i_obs_x,
    input  logic [rnop_pkg::CoordW-1:0]   i_obs_y,
    input  logic                          i_last,
    // result channel
    output logic                          empty,
    input  logic                          pop,
    output logic signed [rnop_pkg::EndW-1:0] o_hit_x,
    output logic signed [rnop_pkg::EndW-1:0] o_hit_y,
    output logic                          o_hit_obstacle,
    // register write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rnop_pkg::IdxW-1:0]     i_cfg_index,
    input  logic [rnop_pkg::CfgDataW-1:0] i_cfg_data
);
    import rnop_pkg::*;

    // coordinate bits above COORD_BITS are masked off and carry nothing
    localparam int EffBits = (COORD_BITS < CoordW) ? COORD_BITS : CoordW;
    localparam logic [CoordW-1:0] CoordMask = CoordW'((32'd1 << EffBits) - 1);

    t_ray        ray;
    t_front_stat fstat;
    t_cand       cand_in, cand_out;
    t_hit        hit_in, hit_out;
    logic        derive_busy, restart;
    logic        cand_full, cand_empty, cand_pop;
    logic        hit_push, hit_full;
    logic        cfg_idle;

    // config is only taken with nothing in flight and no point arriving
    assign cfg_idle = fstat.idle && cand_empty && !push;

    rnop_cfg #(
        .COORD_MASK (CoordMask)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_idle      (cfg_idle),
        .o_ray       (ray),
        .o_busy      (derive_busy),
        .o_restart   (restart)
    );

    rnop_front #(
        .COORD_MASK (CoordMask)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_obs_x       (i_obs_x),
        .i_obs_y       (i_obs_y),
        .i_last        (i_last),
        .o_full        (full),
        .i_ray         (ray),
        .i_derive_busy (derive_busy),
        .o_cand        (cand_in),
        .i_cand_full   (cand_full),
        .o_stat        (fstat)
    );

    // decouples classification from the running minimum
    rnop_fifo #(
        .WIDTH ($bits(t_cand)),
        .DEPTH (CandDepth)
    ) u_cand_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fstat.push),
        .i_data  (cand_in),
        .o_full  (cand_full),
        .i_pop   (cand_pop),
        .o_data  (cand_out),
        .o_empty (cand_empty)
    );

    rnop_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand       (cand_out),
        .i_cand_empty (cand_empty),
        .o_cand_pop   (cand_pop),
        .i_ray        (ray),
        .i_restart    (restart),
        .o_hit        (hit_in),
        .o_hit_push   (hit_push),
        .i_hit_full   (hit_full)
    );

    // result queue: lets the search carry on while a result waits
    rnop_fifo #(
        .WIDTH ($bits(t_hit)),
        .DEPTH (HitDepth)
    ) u_hit_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (hit_push),
        .i_data  (hit_in),
        .o_full  (hit_full),
        .i_pop   (pop),
        .o_data  (hit_out),
        .o_empty (empty)
    );

    assign o_hit_x        = hit_out.x;
    assign o_hit_y        = hit_out.y;
    assign o_hit_obstacle = hit_out.found;

    // candidate queue is never written when full
    a_cand_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fstat.push |-> !cand_full)
        else $error("candidate queue overflow");

    // results are only produced with room in the result queue
    a_hit_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hit_push |-> !hit_full)
        else $error("result queue overflow");

    // register writes only with the datapath empty
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> (fstat.idle && cand_empty))
        else $error("register write with points in flight");

    // a real register write is followed by full, holding off points
    a_full_after_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_ORIGIN_X ||
         i_cfg_index == REG_ORIGIN_Y || i_cfg_index == REG_END_X ||
         i_cfg_index == REG_END_Y)) |=> full)
        else $error("points accepted before derived ray values settle");

    // a chosen obstacle always lies on the map
    a_hit_on_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_hit_obstacle) |-> (!o_hit_x[EndW-1] && !o_hit_y[EndW-1]))
        else $error("obstacle hit off the map");
endmodule
